FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SCE_ASSERT(lbl, prop, msg)
`define SCE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/scenc_pkg.sv
// ----------------------------------------------------------------------------
// Spinal encoder package
// Word types, hash constants and sequencer states for the spinal encoder.
// ----------------------------------------------------------------------------
package scenc_pkg;

	localparam logic [31:0] HASH_MULT     = 32'h045d9f3b;
	localparam logic [31:0] PASS_STEP     = 32'd12345;
	localparam logic [15:0] SPINE_LEN_RST = 16'd32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] symbol;
		logic [1:0]  pass_index;
		logic [15:0] chunk_index;
		logic        end_of_run;
		logic        end_of_message;
	} out_word_t;

	typedef struct packed {
		logic        start;
		logic [31:0] operand;
	} hash_req_t;

	typedef struct packed {
		logic        ready;
		logic [31:0] result;
	} hash_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHUNK,
		ST_SPINE,
		ST_ISSUE,
		ST_WAIT
	} seq_state_t;

endpackage

FILE: hdl/scenc_hash.sv
// ----------------------------------------------------------------------------
// Spinal encoder hash unit
// Multiply-xorshift hash over two multiply steps of one shared multiplier.
// ----------------------------------------------------------------------------
module scenc_hash import scenc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hash_req_t req,
	output hash_rsp_t rsp
);

	logic        busy_q;
	logic        step_q;
	logic        rdy_q;
	logic [31:0] x_q;
	logic [31:0] xs;
	logic [31:0] prod;

	assign xs   = x_q ^ (x_q >> 16);
	assign prod = xs * HASH_MULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			rdy_q  <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= 1'b0;
			rdy_q  <= 1'b0;
		end else if (busy_q) begin
			step_q <= !step_q;
			if (step_q) begin
				busy_q <= 1'b0;
				rdy_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.operand;
		end else if (busy_q) begin
			x_q <= prod;
		end
	end

	assign rsp.ready  = rdy_q;
	assign rsp.result = xs;

endmodule

FILE: hdl/scenc_seq.sv
// ----------------------------------------------------------------------------
// Spinal encoder sequencer
// Splits bytes into chunks, steps the spine and issues one hash per symbol.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module scenc_seq import scenc_pkg::*; #(
	parameter int CHUNK_BITS = 4,
	parameter int PASSES     = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] spine_length,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	output hash_req_t   hreq,
	input  hash_rsp_t   hrsp
);

	localparam int ACC_W  = CHUNK_BITS + 8;
	localparam int NB_W   = $clog2(ACC_W);
	localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

	seq_state_t              state_q, state_d;
	logic [ACC_W-1:0]        acc_q;
	logic [NB_W-1:0]         nbits_q;
	logic [CHUNK_BITS-1:0]   lbits_q;
	logic [NB_W-1:0]         lcnt_q;
	logic [31:0]             spine_q;
	logic [15:0]             done_q;
	logic [15:0]             pos_q;
	logic [PASS_W-1:0]       pass_q;
	logic [31:0]             off_q;
	logic                    out_valid_q;
	out_word_t               out_q;

	logic                    take;
	logic [15:0]             eff_done;
	logic [CHUNK_BITS-1:0]   eff_lbits;
	logic [NB_W-1:0]         eff_lcnt;
	logic                    have_chunk;
	logic                    msg_last;
	logic                    final_pass;
	logic                    run_last;
	logic                    load;

	assign take       = in_valid && in_ready;
	assign eff_done   = in_data.start_message ? 16'd0 : done_q;
	assign eff_lbits  = in_data.start_message ? '0 : lbits_q;
	assign eff_lcnt   = in_data.start_message ? '0 : lcnt_q;
	assign have_chunk = nbits_q >= NB_W'(CHUNK_BITS);
	assign msg_last   = done_q >= spine_length;
	assign final_pass = pass_q == PASS_W'(PASSES - 1);
	assign run_last   = msg_last || !have_chunk;
	assign load       = (state_q == ST_WAIT) && hrsp.ready && (!out_valid_q || out_ready);

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		hreq.start   = 1'b0;
		hreq.operand = spine_q ^ 32'(acc_q[CHUNK_BITS-1:0]);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && eff_done < spine_length) begin
					state_d = ST_CHUNK;
				end
			end
			ST_CHUNK: begin
				if (have_chunk) begin
					hreq.start = 1'b1;
					state_d    = ST_SPINE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SPINE: begin
				if (hrsp.ready) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				hreq.start   = 1'b1;
				hreq.operand = spine_q + off_q;
				state_d      = ST_WAIT;
			end
			ST_WAIT: begin
				if (load) begin
					state_d = final_pass ? ST_CHUNK : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nbits_q     <= '0;
			lbits_q     <= '0;
			lcnt_q      <= '0;
			spine_q     <= '0;
			done_q      <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						lbits_q <= eff_lbits;
						lcnt_q  <= eff_lcnt;
						done_q  <= eff_done;
						nbits_q <= eff_lcnt + NB_W'(8);
						if (in_data.start_message) begin
							spine_q <= '0;
						end
					end
				end
				ST_CHUNK: begin
					if (have_chunk) begin
						nbits_q <= nbits_q - NB_W'(CHUNK_BITS);
					end else begin
						lbits_q <= acc_q[CHUNK_BITS-1:0];
						lcnt_q  <= nbits_q;
					end
				end
				ST_SPINE: begin
					if (hrsp.ready) begin
						spine_q <= hrsp.result;
						done_q  <= done_q + 16'd1;
						pass_q  <= '0;
					end
				end
				ST_ISSUE: begin
				end
				ST_WAIT: begin
					if (load) begin
						if (final_pass) begin
							if (msg_last) begin
								nbits_q <= '0;
							end
						end else begin
							pass_q <= pass_q + PASS_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= ACC_W'(eff_lbits) | (ACC_W'(in_data.data_byte) << eff_lcnt);
		end else if (state_q == ST_CHUNK && have_chunk) begin
			acc_q <= acc_q >> CHUNK_BITS;
		end else if (load && final_pass && msg_last) begin
			acc_q <= '0;
		end
		if (state_q == ST_CHUNK) begin
			pos_q <= done_q;
		end
		if (state_q == ST_SPINE) begin
			off_q <= '0;
		end else if (load) begin
			off_q <= off_q + PASS_STEP;
		end
		if (load) begin
			out_q.symbol         <= hrsp.result;
			out_q.pass_index     <= 2'(pass_q);
			out_q.chunk_index    <= pos_q;
			out_q.end_of_run     <= final_pass && run_last;
			out_q.end_of_message <= final_pass && msg_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SCE_ASSERT_NEVER(a_no_overwrite, load && out_valid_q && !out_ready, "held word overwritten")
	`SCE_ASSERT(a_eom_ends_run, out_valid_q |-> (!out_q.end_of_message || out_q.end_of_run), "end of message without end of run")
	`SCE_ASSERT(a_pass_range, pass_q <= PASS_W'(PASSES - 1), "pass counter out of range")
	`SCE_ASSERT(a_load_after_issue, load |-> $past(state_q) == ST_WAIT || $past(state_q) == ST_ISSUE, "symbol loaded without an issued hash")

endmodule

FILE: hdl/spinal_code_encoder.sv
// ----------------------------------------------------------------------------
// Spinal code encoder
// Rateless spinal encoder: bytes in, hashed 32-bit symbols out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_ready    in_word_t (data_byte, start_message)
// out       output     out_valid / out_ready  out_word_t (symbol, pass, chunk, flags)
// cfg       input      cfg_we                 cfg_wdata, spine length
//
// The shared hash unit needs two multiply steps for each hash.
// Bytes are taken one at a time; the next byte may enter while a word waits.
// A stalled output holds the sequencer only when the next symbol is ready.
// Reset clears the spine, the chunk count and the leftover bits.
// ----------------------------------------------------------------------------
module spinal_code_encoder import scenc_pkg::*; #(
	parameter int CHUNK_BITS = 4,
	parameter int PASSES     = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] len_q;
	hash_req_t   hreq;
	hash_rsp_t   hrsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= SPINE_LEN_RST;
		end else if (cfg_we) begin
			len_q <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
		end
	end

	scenc_seq #(
		.CHUNK_BITS (CHUNK_BITS),
		.PASSES     (PASSES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.spine_length (len_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.hreq         (hreq),
		.hrsp         (hrsp)
	);

	scenc_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

endmodule

FILE: tb/tb_spinal_code_encoder.sv
// ----------------------------------------------------------------------------
// Spinal code encoder testbench
// Sends message bytes on the input channel, predicts every symbol word from an
// internal model of the spine hash, and checks each output word in order.
// Directed tests cover the reset length, the extremes of spine_length, a stop
// inside a byte and length changes mid-message. Random messages then run under
// three idling schemes, and one test stalls the output long enough to fill
// the block.
// ----------------------------------------------------------------------------
module tb_spinal_code_encoder import scenc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHUNK_BITS    = 4;
	localparam int PASSES        = 3;
	localparam int SETTLE_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	logic [31:0] model_spine;
	logic [15:0] model_chunks;
	logic [7:0]  model_carry_bits;
	logic [3:0]  model_carry_count;
	logic [15:0] model_spine_len;

	out_word_t   pending_symbols[$];
	int          mismatch_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          out_hold_cycles;

	spinal_code_encoder #(
		.CHUNK_BITS(CHUNK_BITS),
		.PASSES(PASSES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] spine_hash(input logic [31:0] x);
		logic [31:0] v;
		v = x ^ (x >> 16);
		v = v * HASH_MULT;
		v = v ^ (v >> 16);
		v = v * HASH_MULT;
		v = v ^ (v >> 16);
		return v;
	endfunction

	task automatic encode_byte(input in_word_t w, output int count);
		logic [15:0] acc;
		int          nbits;
		logic [15:0] pos;
		logic        last;
		out_word_t   sym;
		out_word_t   batch[$];
		count = 0;
		if (w.start_message) begin
			model_spine       = '0;
			model_chunks      = '0;
			model_carry_bits  = '0;
			model_carry_count = '0;
		end
		if (model_chunks >= model_spine_len)
			return;
		acc   = 16'(model_carry_bits) | (16'(w.data_byte) << model_carry_count);
		nbits = int'(model_carry_count) + 8;
		while (nbits >= CHUNK_BITS) begin
			pos          = model_chunks;
			model_spine  = spine_hash(model_spine ^ 32'(acc[CHUNK_BITS-1:0]));
			acc          = acc >> CHUNK_BITS;
			nbits        = nbits - CHUNK_BITS;
			model_chunks = model_chunks + 16'd1;
			last         = model_chunks >= model_spine_len;
			for (int p = 0; p < PASSES; p++) begin
				sym.symbol         = spine_hash(model_spine + 32'(p) * PASS_STEP);
				sym.pass_index     = 2'(p);
				sym.chunk_index    = pos;
				sym.end_of_run     = 1'b0;
				sym.end_of_message = last && (p == PASSES - 1);
				batch.push_back(sym);
			end
			if (last) begin
				acc   = '0;
				nbits = 0;
				break;
			end
		end
		model_carry_bits  = acc[7:0];
		model_carry_count = 4'(nbits);
		count = batch.size();
		if (count > 0)
			batch[count-1].end_of_run = 1'b1;
		foreach (batch[i])
			pending_symbols.push_back(batch[i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st, output int count);
		in_word_t w;
		w.data_byte     = b;
		w.start_message = st;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		encode_byte(w, count);
	endtask

	task automatic send_message(input logic [7:0] bytes[$], input logic first_start);
		int count;
		foreach (bytes[i])
			send_byte(bytes[i], (i == 0) ? first_start : 1'b0, count);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_spine_length(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_spine_len = (value == 16'd0) ? 16'd1 : value;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (out_hold_cycles > 0) begin
			out_ready <= 1'b0;
			out_hold_cycles = out_hold_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void report_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_symbols.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual 0x%0h",
					$time, out_data);
				mismatch_count++;
			end else begin
				exp_w = pending_symbols.pop_front();
				report_field("symbol", exp_w.symbol, out_data.symbol);
				report_field("pass_index", 32'(exp_w.pass_index), 32'(out_data.pass_index));
				report_field("chunk_index", 32'(exp_w.chunk_index), 32'(out_data.chunk_index));
				report_field("end_of_run", 32'(exp_w.end_of_run), 32'(out_data.end_of_run));
				report_field("end_of_message", 32'(exp_w.end_of_message),
					32'(out_data.end_of_message));
			end
		end
	end

	// The default length of 32 chunks with bytes at both extremes.
	task automatic test_reset_length();
		send_message('{8'h00, 8'hff, 8'ha5, 8'h5a}, 1'b1);
		wait_idle();
	endtask

	// A written zero acts as one chunk, so only a message's first low nibble is encoded.
	task automatic test_zero_length();
		write_spine_length(16'd0);
		send_message('{8'hff, 8'h12}, 1'b1);
		send_message('{8'h00}, 1'b1);
		wait_idle();
		write_spine_length(16'hffff);
		send_message('{8'h80, 8'h01, 8'hfe}, 1'b1);
		wait_idle();
	endtask

	// An odd length stops inside a byte; later bytes are ignored until a new start.
	task automatic test_stop_in_byte();
		write_spine_length(16'd3);
		send_message('{8'h3c, 8'hc3, 8'h77, 8'h11}, 1'b1);
		send_message('{8'h96, 8'h69}, 1'b1);
		wait_idle();
	endtask

	// Lowering the length ends the message; raising it lets the message go on.
	task automatic test_length_change();
		write_spine_length(16'd8);
		send_message('{8'h21, 8'h43}, 1'b1);
		wait_idle();
		write_spine_length(16'd3);
		send_message('{8'h65}, 1'b0);
		wait_idle();
		write_spine_length(16'd7);
		send_message('{8'h87, 8'ha9}, 1'b0);
		wait_idle();
	endtask

	// The output holds off for a long stretch while bytes keep arriving.
	task automatic test_output_stall();
		logic [7:0] bytes[$];
		write_spine_length(16'd200);
		repeat (24) bytes.push_back(8'($urandom_range(255)));
		out_hold_cycles = 400;
		send_message(bytes, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_messages(input int s_pct, input int r_pct, input int target);
		int         produced;
		int         len;
		int         nbytes;
		int         count;
		logic       st;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		produced = 0;
		while (produced < target) begin
			wait_idle();
			case ($urandom_range(9)) inside
				[0:6]: len = $urandom_range(1, 12);
				[7:8]: len = $urandom_range(13, 80);
				default: len = ($urandom_range(1) == 0) ? 0 : 65535;
			endcase
			write_spine_length(16'(len));
			repeat ($urandom_range(2, 5)) begin
				nbytes = (len + 1) / 2 + $urandom_range(0, 2);
				if (nbytes > 40)
					nbytes = 40;
				for (int i = 0; i < nbytes; i++) begin
					if (i == 0)
						st = ($urandom_range(9) != 0);
					else
						st = ($urandom_range(19) == 0);
					send_byte(8'($urandom_range(255)), st, count);
					produced++;
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_data         = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		mismatch_count  = 0;
		out_hold_cycles = 0;
		send_idle_pct   = 21;
		recv_idle_pct   = 58;
		model_spine       = '0;
		model_chunks      = '0;
		model_carry_bits  = '0;
		model_carry_count = '0;
		model_spine_len   = SPINE_LEN_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_length();
		test_zero_length();
		test_stop_in_byte();
		test_length_change();
		test_output_stall();
		test_random_messages(21, 58, 130);
		test_random_messages(58, 21, 130);
		test_random_messages(0, 0, 130);

		if (mismatch_count == 0 && pending_symbols.size() == 0)
			$display("tb_spinal_code_encoder: PASS");
		else
			$display("tb_spinal_code_encoder: FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb_spinal_code_encoder: FAIL");
		$finish;
	end

endmodule
